// ===== design/srfr_pkg.sv =====
// Shared constants, command/status structs and sizes for the segmented frame reassembler.
// No dependencies; imported by srfr_ctrl, srfr_dp and the top level.
`default_nettype none

package srfr_pkg;

  // Largest message kept in the payload store, in bytes.
  localparam int MAX_MSG_LEN = 255;

  // Byte lanes of a frame and of an output chunk.
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = $clog2(NUM_LANES);

  // Payload store: one RAM per byte lane, one row per chunk.
  localparam int ROWS  = (MAX_MSG_LEN + NUM_LANES - 1) / NUM_LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int LEN_W = 8;
  localparam int ID_W  = 14;
  localparam int CNT_W = 32;

  // Frame markers and type codes.
  localparam logic [7:0]  SEQ_START       = 8'h21;
  localparam logic [7:0]  SEQ_WRAP_HI     = 8'h2F;
  localparam logic [7:0]  SEQ_WRAP_LO     = 8'h20;
  localparam logic [7:0]  TYPE_BASE       = 8'hB0;
  localparam logic [7:0]  TYPE_SINGLE_MIN = 8'hB1;
  localparam logic [7:0]  TYPE_SINGLE_MAX = 8'hB4;
  localparam logic [7:0]  TYPE_END        = 8'hC0;
  localparam logic [7:0]  LEN_ESCAPE      = 8'hC1;
  localparam logic [15:0] ID_LIMIT        = 16'd10000;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the incoming frame
    logic apply;       // evaluate the frame and update state and store
    logic read_first;  // read chunk row 0
    logic advance;     // chunk taken, read the next row
  } srfr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_req;    // the evaluated frame completes a message
    logic last;        // the chunk on the output is the final one
  } srfr_sts_t;

endpackage

`default_nettype wire

// ===== design/srfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/srfr_ctrl.sv =====
// Controller state machine of the reassembler: sequences capture, evaluation and chunk readout.
// Depends on srfr_pkg.
`default_nettype none

module srfr_ctrl
  import srfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  srfr_sts_t sts,
  output srfr_cmd_t cmd,
  output logic      in_ready,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = sts.emit_req ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready && sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign cmd.capture    = (state_r == S_IDLE) && in_valid;
  assign cmd.apply      = (state_r == S_EVAL);
  assign cmd.read_first = (state_r == S_READ);
  assign cmd.advance    = (state_r == S_OUT) && out_ready && !sts.last;

endmodule

`default_nettype wire

// ===== design/srfr_dp.sv =====
// Datapath of the reassembler: frame register, message state, lane RAMs and chunk formatting.
// Depends on srfr_pkg and srfr_ram.
`default_nettype none

module srfr_dp
  import srfr_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  srfr_cmd_t                        cmd,
  input  logic [3:0]                       frame_len,
  input  logic [NUM_LANES-1:0][7:0]        frame_bytes,
  output srfr_sts_t                        sts,
  output logic [ID_W-1:0]                  msg_id,
  output logic [LEN_W-1:0]                 msg_len,
  output logic [NUM_LANES-1:0][7:0]        data,
  output logic                             last_chunk,
  output logic [CNT_W-1:0]                 abandoned_total
);

  // Captured frame
  logic [3:0]                n_r;
  logic [NUM_LANES-1:0][7:0] frame_r;

  // Message state
  logic              assembling_r;
  logic [ID_W-1:0]   pending_id_r;
  logic [LEN_W-1:0]  needed_r;
  logic [LEN_W-1:0]  held_r;
  logic [7:0]        exp_seq_r;
  logic [CNT_W-1:0]  abandoned_r;
  logic [ROW_W-1:0]  chunk_r;

  // Decode
  logic             n_zero;
  logic             cont_hit;
  logic [3:0]       take_raw;
  logic [8:0]       held_sum;
  logic [8:0]       room;
  logic [2:0]       take;
  logic [LEN_W-1:0] cont_held;
  logic [7:0]       typ;
  logic [15:0]      id16;
  logic             hdr_ok;
  logic             id_ok;
  logic             is_single;
  logic             is_b0;
  logic             esc;
  logic [7:0]       single_len;
  logic [7:0]       b0_len;
  logic             single_ok;
  logic             b0_ok;
  logic [7:0]       start_len;
  logic [3:0]       start_off;
  logic             start_ok;
  logic [3:0]       have_raw;
  logic [7:0]       start_have;
  logic             open_done;
  logic             emit_req;
  logic             is_last;

  // Store write
  logic             wr_any;
  logic [LEN_W-1:0] wr_base;
  logic [2:0]       wr_src;
  logic [2:0]       wr_cnt;

  logic [NUM_LANES-1:0]            lane_we;
  logic [ROW_W-1:0]                lane_row [NUM_LANES];
  logic [NUM_LANES-1:0][7:0]       lane_wd;
  logic [NUM_LANES-1:0][7:0]       lane_rd;
  logic                            rd_en;
  logic [ROW_W-1:0]                rd_row;
  logic [ROW_W-1:0]                last_row;

  always_comb begin
    n_zero   = (n_r == 4'd0);
    cont_hit = assembling_r && (frame_r[0] == exp_seq_r);

    // Continuation: take the bytes after the sequence byte, clamp to the store size.
    take_raw  = n_r - 4'd1;
    held_sum  = {1'b0, held_r} + {6'b0, take_raw[2:0]};
    room      = 9'(MAX_MSG_LEN) - {1'b0, held_r};
    take      = (held_sum > 9'(MAX_MSG_LEN)) ? room[2:0] : take_raw[2:0];
    cont_held = held_r + {5'b0, take};

    // Start frame
    typ    = frame_r[3];
    id16   = {frame_r[2], frame_r[1]};
    hdr_ok = (n_r > 4'd4) && (frame_r[0] == SEQ_START) && (typ >= TYPE_BASE) &&
             (typ < TYPE_END);
    id_ok  = (id16 != 16'd0) && (id16 < ID_LIMIT);

    is_single  = (typ >= TYPE_SINGLE_MIN) && (typ <= TYPE_SINGLE_MAX);
    is_b0      = (typ == TYPE_BASE);
    single_len = typ - TYPE_BASE;
    single_ok  = (8'd4 + single_len) <= {4'b0, n_r};

    esc    = (frame_r[4] == LEN_ESCAPE);
    b0_len = esc ? frame_r[5] : frame_r[4];
    b0_ok  = (!esc || (n_r >= 4'd6)) && (b0_len != 8'd0) &&
             ({1'b0, b0_len} <= 9'(MAX_MSG_LEN));

    if (is_b0) begin
      start_len = b0_len;
      start_off = esc ? 4'd6 : 4'd5;
      start_ok  = hdr_ok && id_ok && b0_ok;
    end else begin
      // single-frame and nibble-length types share the same layout
      start_len = single_len;
      start_off = 4'd4;
      start_ok  = hdr_ok && id_ok && (!is_single || single_ok);
    end

    have_raw   = (n_r > start_off) ? (n_r - start_off) : 4'd0;
    start_have = ({4'b0, have_raw} > start_len) ? start_len : {4'b0, have_raw};
    open_done  = (start_have >= start_len);

    // Store write: continuation appends, start overwrites from row 0.
    if (cont_hit) begin
      wr_any  = 1'b1;
      wr_base = held_r;
      wr_src  = 3'd1;
      wr_cnt  = take;
    end else begin
      wr_any  = start_ok;
      wr_base = '0;
      wr_src  = start_off[2:0];
      wr_cnt  = start_have[2:0];
    end

    if (n_zero) begin
      emit_req = 1'b0;
    end else if (cont_hit) begin
      emit_req = (cont_held >= needed_r);
    end else begin
      emit_req = start_ok && (is_single || open_done);
    end
  end

  // Steer each frame byte to the lane RAM of its message position.
  always_comb begin
    logic [2:0] off;
    logic [8:0] pos;
    logic [2:0] src;
    for (int b = 0; b < NUM_LANES; b++) begin
      off         = 3'(b) - wr_base[2:0];
      pos         = {1'b0, wr_base} + {6'b0, off};
      src         = wr_src + off;
      lane_we[b]  = cmd.apply && !n_zero && wr_any && (off < wr_cnt);
      lane_row[b] = ROW_W'(pos >> LANE_W);
      lane_wd[b]  = frame_r[src];
    end
  end

  assign rd_en  = cmd.read_first || cmd.advance;
  assign rd_row = cmd.advance ? (chunk_r + ROW_W'(1)) : chunk_r;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    srfr_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_lane_ram (
      .clk   (clk),
      .we    (lane_we[g]),
      .waddr (lane_row[g]),
      .wdata (lane_wd[g]),
      .re    (rd_en),
      .raddr (rd_row),
      .rdata (lane_rd[g])
    );
  end

  // Frame capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r     <= (frame_len > 4'd8) ? 4'd8 : frame_len;
      frame_r <= frame_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assembling_r <= 1'b0;
      pending_id_r <= '0;
      needed_r     <= '0;
      held_r       <= '0;
      exp_seq_r    <= '0;
      abandoned_r  <= '0;
      chunk_r      <= '0;
    end else begin
      if (cmd.apply) begin
        chunk_r <= '0;
        if (!n_zero) begin
          if (cont_hit) begin
            held_r    <= cont_held;
            exp_seq_r <= (exp_seq_r >= SEQ_WRAP_HI) ? SEQ_WRAP_LO : (exp_seq_r + 8'd1);
            if (cont_held >= needed_r) begin
              assembling_r <= 1'b0;
            end
          end else begin
            if (assembling_r) begin
              assembling_r <= 1'b0;
              abandoned_r  <= abandoned_r + CNT_W'(1);
            end
            if (start_ok) begin
              pending_id_r <= id16[ID_W-1:0];
              needed_r     <= start_len;
              if (!is_single) begin
                assembling_r <= !open_done;
                held_r       <= start_have;
                exp_seq_r    <= frame_r[0] + 8'd1;
              end
            end
          end
        end
      end else if (cmd.advance) begin
        chunk_r <= chunk_r + ROW_W'(1);
      end
    end
  end

  // Chunk formatting: zero the bytes past the message end.
  always_comb begin
    logic [8:0] pos;
    for (int j = 0; j < NUM_LANES; j++) begin
      pos     = 9'({chunk_r, 3'(j)});
      data[j] = (pos < {1'b0, needed_r}) ? lane_rd[j] : 8'd0;
    end
  end

  assign last_row        = ROW_W'((needed_r - 8'd1) >> LANE_W);
  assign is_last         = (chunk_r == last_row);
  assign sts.emit_req    = emit_req;
  assign sts.last        = is_last;
  assign last_chunk      = is_last;
  assign msg_id          = pending_id_r;
  assign msg_len         = needed_r;
  assign abandoned_total = abandoned_r;

endmodule

`default_nettype wire

// ===== design/segmented_frame_reassembler.sv =====
// Top level of the segmented frame reassembler: controller, datapath and port assertions.
// Depends on srfr_pkg, srfr_ctrl, srfr_dp (and srfr_ram through srfr_dp).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | in_frame_len, in_byte_0..in_byte_7
//  out     | out_valid / out_ready| out_msg_id, out_msg_len, out_data_0..7,
//          |                      | out_last_chunk, out_abandoned_total
//
// Sequence: a frame that completes nothing is accepted and then evaluated; a frame that
// completes a message is then followed by a registered read of row 0 of the lane RAMs,
// after which the lane RAMs stream one 8-byte chunk per cycle while out_ready is held high.
// Reset: synchronous, active low; the payload store needs no clearing pass.
// Stalls: out_ready low holds the current chunk; in_ready stays low until the last chunk
// transaction of a message completes.
`default_nettype none

module segmented_frame_reassembler
  import srfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_frame_len,
  input  logic [7:0]        in_byte_0,
  input  logic [7:0]        in_byte_1,
  input  logic [7:0]        in_byte_2,
  input  logic [7:0]        in_byte_3,
  input  logic [7:0]        in_byte_4,
  input  logic [7:0]        in_byte_5,
  input  logic [7:0]        in_byte_6,
  input  logic [7:0]        in_byte_7,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_msg_id,
  output logic [LEN_W-1:0]  out_msg_len,
  output logic [7:0]        out_data_0,
  output logic [7:0]        out_data_1,
  output logic [7:0]        out_data_2,
  output logic [7:0]        out_data_3,
  output logic [7:0]        out_data_4,
  output logic [7:0]        out_data_5,
  output logic [7:0]        out_data_6,
  output logic [7:0]        out_data_7,
  output logic              out_last_chunk,
  output logic [CNT_W-1:0]  out_abandoned_total
);

  srfr_cmd_t                 cmd;
  srfr_sts_t                 sts;
  logic [NUM_LANES-1:0][7:0] frame_bytes;
  logic [NUM_LANES-1:0][7:0] chunk_data;

  // Byte 0 sits in lane 0.
  assign frame_bytes = {in_byte_7, in_byte_6, in_byte_5, in_byte_4,
                        in_byte_3, in_byte_2, in_byte_1, in_byte_0};

  srfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  srfr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .frame_len       (in_frame_len),
    .frame_bytes     (frame_bytes),
    .sts             (sts),
    .msg_id          (out_msg_id),
    .msg_len         (out_msg_len),
    .data            (chunk_data),
    .last_chunk      (out_last_chunk),
    .abandoned_total (out_abandoned_total)
  );

  assign out_data_0 = chunk_data[0];
  assign out_data_1 = chunk_data[1];
  assign out_data_2 = chunk_data[2];
  assign out_data_3 = chunk_data[3];
  assign out_data_4 = chunk_data[4];
  assign out_data_5 = chunk_data[5];
  assign out_data_6 = chunk_data[6];
  assign out_data_7 = chunk_data[7];

  // Input and output sides never run at once: one frame at a time.
  a_one_side : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // A taken chunk that is not the last is followed by the next chunk at once.
  a_chunk_stream : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_chunk |=> out_valid)
    else $error("chunk stream broken before last chunk");

  // An accepted frame is evaluated before another one is taken.
  a_eval_gap : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("frame accepted during evaluation");

  // Every emitted message has a nonzero length.
  a_len_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_msg_len != '0)
    else $error("chunk with zero message length");

endmodule

`default_nettype wire
